### hw/rtl/census_window_transform_assert.svh
// ----------------------------------------------------------------------------
// census window transform assertion macros
// concurrent checks clocked on clk and disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef CENSUS_WINDOW_TRANSFORM_ASSERT_SVH
`define CENSUS_WINDOW_TRANSFORM_ASSERT_SVH

// same-cycle implication
`define CWT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("census window transform check failed");

// next-cycle implication
`define CWT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("census window transform check failed");

`endif

### hw/rtl/cwt_pkg.sv
// ----------------------------------------------------------------------------
// cwt_pkg
// shared widths, register codes and position type of the census transform
// ----------------------------------------------------------------------------
package cwt_pkg;

  localparam int RADIUS_DEF    = 3;
  localparam int MAX_WIDTH_DEF = 1024;

  localparam int PIX_W      = 8;
  localparam int CENSUS_W   = 48;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 10;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 12;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;

  localparam logic [IMG_W_W-1:0] WIDTH_RESET  = IMG_W_W'(640);
  localparam logic [IMG_H_W-1:0] HEIGHT_RESET = IMG_H_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } cwt_pos_t;

  typedef struct packed {
    logic     shift;
    logic     emit;
    cwt_pos_t pos;
  } cwt_win_ctl_t;

endpackage

### hw/rtl/cwt_if.sv
// ----------------------------------------------------------------------------
// cwt stream interfaces
// valid/ready channels for input pixels and census results
// ----------------------------------------------------------------------------
interface cwt_pixel_if;
  import cwt_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface cwt_census_if;
  import cwt_pkg::*;
  logic                valid;
  logic                ready;
  logic [CENSUS_W-1:0] census_bits;
  logic [ROW_W-1:0]    center_row;
  logic [COL_W-1:0]    center_col;
  logic                last_of_frame;

  modport source (output valid, output census_bits, output center_row,
                  output center_col, output last_of_frame, input ready);
  modport sink   (input valid, input census_bits, input center_row,
                  input center_col, input last_of_frame, output ready);
endinterface

### hw/rtl/cwt_line_store.sv
// ----------------------------------------------------------------------------
// cwt_line_store
// column history memory, one entry per image column, registered read,
// write-to-read forwarding for the same entry in the same cycle
// ----------------------------------------------------------------------------
module cwt_line_store #(
  parameter int RADIUS    = cwt_pkg::RADIUS_DEF,
  parameter int MAX_WIDTH = cwt_pkg::MAX_WIDTH_DEF,
  parameter int LS_BITS   = 16 * RADIUS,
  parameter int IDX_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_addr,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  logic [LS_BITS-1:0] wr_data,
  output logic [LS_BITS-1:0] rd_data
);
  import cwt_pkg::*;

  logic [LS_BITS-1:0] mem [MAX_WIDTH];
  logic [LS_BITS-1:0] rd_raw;
  logic [LS_BITS-1:0] fwd_data;
  logic               fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw   <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (rd_en) begin
      fwd <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd ? fwd_data : rd_raw;

endmodule

### hw/rtl/cwt_window.sv
// ----------------------------------------------------------------------------
// cwt_window
// sliding window of pixel columns, census compare stage and output register
// ----------------------------------------------------------------------------
module cwt_window #(
  parameter int RADIUS   = cwt_pkg::RADIUS_DEF,
  parameter int SPAN     = 2 * RADIUS + 1,
  parameter int COL_BITS = 8 * SPAN
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cwt_pkg::cwt_win_ctl_t ctl,
  input  logic [COL_BITS-1:0]   column,
  output logic                  s2_free,
  cwt_census_if.source          census
);
  import cwt_pkg::*;

  localparam int NB     = SPAN * SPAN - 1;
  localparam int CENTER = RADIUS * SPAN + RADIUS;

  logic [COL_BITS-1:0] win [SPAN];
  logic                s2_valid;
  cwt_pos_t            s2_pos;
  logic                c_en;
  logic [PIX_W-1:0]    mid;
  logic [NB-1:0]       cmp;

  assign c_en    = !census.valid || census.ready;
  assign s2_free = !s2_valid || c_en;
  assign mid     = win[RADIUS][PIX_W*RADIUS +: PIX_W];

  // top-left neighbour lands in the highest used bit
  for (genvar gu = 0; gu < SPAN; gu++) begin : g_row
    for (genvar gv = 0; gv < SPAN; gv++) begin : g_col
      localparam int P = gu * SPAN + gv;
      localparam int B = (P > CENTER) ? (NB - P) : (NB - 1 - P);
      if (P != CENTER) begin : g_bit
        assign cmp[B] = win[gv][PIX_W*(2*RADIUS-gu) +: PIX_W] >= mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      for (int k = 0; k < SPAN - 1; k++) begin
        win[k] <= win[k+1];
      end
      win[SPAN-1] <= column;
      s2_pos      <= ctl.pos;
    end
    if (c_en && s2_valid) begin
      census.census_bits   <= CENSUS_W'(cmp);
      census.center_row    <= s2_pos.row;
      census.center_col    <= s2_pos.col;
      census.last_of_frame <= s2_pos.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid     <= 1'b0;
      census.valid <= 1'b0;
    end else begin
      if (ctl.shift) begin
        s2_valid <= ctl.emit;
      end else if (c_en) begin
        s2_valid <= 1'b0;
      end
      if (c_en) begin
        census.valid <= s2_valid;
      end
    end
  end

endmodule

### hw/rtl/census_window_transform.sv
// ----------------------------------------------------------------------------
// census_window_transform
// streaming census transform over a square window around each interior pixel
// ----------------------------------------------------------------------------
//  channel   dir  payload                                          beat
//  pixels    in   pixel                                            one pixel
//  census    out  census_bits center_row center_col last_of_frame  one word
//  cfg       in   cfg_index cfg_data                               one write
//
//  one pixel per cycle unless census stalls, limited by the single line store port pair
//  after the pixel that completes its window, a result passes the line store read,
//  the window shift and the census compare into the output register
//  reset clears counters and config to defaults, line store needs no clearing
//  a stalled census output holds the pipe, pixels are taken while stages drain
// ----------------------------------------------------------------------------
`include "census_window_transform_assert.svh"

module census_window_transform #(
  parameter int RADIUS    = cwt_pkg::RADIUS_DEF,
  parameter int MAX_WIDTH = cwt_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cwt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cwt_pkg::CFG_DATA_W-1:0] cfg_data,
  cwt_pixel_if.sink                     pixels,
  cwt_census_if.source                  census
);
  import cwt_pkg::*;

  localparam int SPAN     = 2 * RADIUS + 1;
  localparam int LS_BITS  = 16 * RADIUS;
  localparam int COL_BITS = 8 * SPAN;
  localparam int IDX_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EDGE     = 2 * RADIUS;
  localparam int WC_W     = ($clog2(MAX_WIDTH + 1) > IMG_W_W) ?
                            $clog2(MAX_WIDTH + 1) : IMG_W_W;

  logic [IMG_W_W-1:0] image_width;
  logic [IMG_H_W-1:0] image_height;
  logic [ROW_W-1:0]   row_count;
  logic [COL_W-1:0]   col_count;

  logic [WC_W-1:0]    w_eff;
  logic [IMG_H_W-1:0] h_eff;
  logic [WC_W-1:0]    c_ext;
  logic [WC_W-1:0]    c_plus;
  logic [ROW_W:0]     r_plus;
  logic               c_wrap;
  logic               r_wrap;
  logic               emit;
  logic               last;
  logic               accept;

  logic               s1_valid;
  logic [PIX_W-1:0]   s1_pix;
  logic [IDX_W-1:0]   s1_idx;
  logic               s1_emit;
  cwt_pos_t           s1_pos;
  logic               s1_move;
  logic               s2_free;

  logic [IDX_W-1:0]    rd_idx;
  logic [LS_BITS-1:0]  ls_rd_data;
  logic [COL_BITS-1:0] column;
  cwt_win_ctl_t        win_ctl;

  always_comb begin
    if (image_width == '0) begin
      w_eff = WC_W'(1);
    end else if (WC_W'(image_width) > WC_W'(MAX_WIDTH)) begin
      w_eff = WC_W'(MAX_WIDTH);
    end else begin
      w_eff = WC_W'(image_width);
    end
  end

  assign h_eff  = (image_height == '0) ? IMG_H_W'(1) : image_height;
  assign c_ext  = WC_W'(col_count);
  assign c_plus = c_ext + WC_W'(1);
  assign r_plus = {1'b0, row_count} + (ROW_W+1)'(1);
  assign c_wrap = c_plus >= w_eff;
  assign r_wrap = r_plus >= {1'b0, h_eff};
  assign emit   = (row_count >= ROW_W'(EDGE)) && (col_count >= COL_W'(EDGE)) &&
                  (row_count < h_eff) && (c_ext < w_eff);
  assign last   = (row_count == h_eff - IMG_H_W'(1)) && (c_ext == w_eff - WC_W'(1));

  assign s1_move      = s1_valid && s2_free;
  assign pixels.ready = !s1_valid || s2_free;
  assign accept       = pixels.valid && pixels.ready;
  assign rd_idx       = IDX_W'(col_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      row_count    <= '0;
      col_count    <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_W_W-1:0];
          REG_IMAGE_HEIGHT: image_height <= cfg_data[IMG_H_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (c_wrap) begin
          col_count <= '0;
          row_count <= r_wrap ? '0 : r_plus[ROW_W-1:0];
        end else begin
          col_count <= c_plus[COL_W-1:0];
        end
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix      <= pixels.pixel;
      s1_idx      <= rd_idx;
      s1_emit     <= emit;
      s1_pos.row  <= row_count - ROW_W'(RADIUS);
      s1_pos.col  <= col_count - COL_W'(RADIUS);
      s1_pos.last <= last;
    end
  end

  assign column = {ls_rd_data, s1_pix};

  cwt_line_store #(
    .RADIUS    (RADIUS),
    .MAX_WIDTH (MAX_WIDTH),
    .LS_BITS   (LS_BITS),
    .IDX_W     (IDX_W)
  ) u_line_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (rd_idx),
    .wr_en   (s1_move),
    .wr_addr (s1_idx),
    .wr_data (column[LS_BITS-1:0]),
    .rd_data (ls_rd_data)
  );

  assign win_ctl.shift = s1_move;
  assign win_ctl.emit  = s1_emit;
  assign win_ctl.pos   = s1_pos;

  cwt_window #(
    .RADIUS   (RADIUS),
    .SPAN     (SPAN),
    .COL_BITS (COL_BITS)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .ctl     (win_ctl),
    .column  (column),
    .s2_free (s2_free),
    .census  (census)
  );

  `CWT_ASSERT_NXT(a_frame_wrap, accept && c_wrap && r_wrap, (row_count == '0) && (col_count == '0))
  `CWT_ASSERT_IMP(a_col_bound, 1'b1, c_ext < WC_W'(MAX_WIDTH))
  `CWT_ASSERT_NXT(a_ls_forward, accept && s1_move && (s1_idx == rd_idx), ls_rd_data == $past(column[LS_BITS-1:0]))

endmodule
